// File: rtl/light_sensor_block_averager_macros.svh
// assertion macros shared by the light sensor block averager rtl
// no dependencies; bodies are empty when SYNTH is defined
`ifndef LIGHT_SENSOR_BLOCK_AVERAGER_MACROS_SVH
`define LIGHT_SENSOR_BLOCK_AVERAGER_MACROS_SVH

`ifndef SYNTH
`define LSBA_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lsba: assertion failed");
`define LSBA_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lsba: assertion failed");
`else
`define LSBA_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define LSBA_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// File: rtl/lsba_pkg.sv
// types, codes and constants of the light sensor block averager
// no dependencies
package lsba_pkg;

  localparam int ADC_BITS   = 10;
  localparam int COEF_BITS  = 22;
  localparam int PROD_BITS  = ADC_BITS + COEF_BITS;
  localparam int FRAC_SHIFT = 8;
  localparam int LUX_BITS   = 24;
  localparam int SUM_BITS   = 40;
  localparam int TIME_BITS  = 32;
  localparam int DIV_CNT_W  = $clog2(SUM_BITS + 1);

  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 32;

  localparam logic [CFG_IDX_BITS-1:0] CFG_GAIN_MODE       = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_SAMPLE_COUNT    = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_REPORT_INTERVAL = 2'd2;

  localparam logic [1:0] GAIN_OFF  = 2'd0;
  localparam logic [1:0] GAIN_LOW  = 2'd1;
  localparam logic [1:0] GAIN_MED  = 2'd2;
  localparam logic [1:0] GAIN_HIGH = 2'd3;

  localparam logic [TIME_BITS-1:0] INTERVAL_RESET = 32'd1000;

  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_STATUS = 1'b1;

  localparam logic CAUSE_PERIODIC = 1'b0;
  localparam logic CAUSE_STATUS   = 1'b1;

  // unsigned q6.16 lux per count, (3.3/1024) times the sensor response
  localparam logic [COEF_BITS-1:0] COEF_LOW  = 22'd3911111;
  localparam logic [COEF_BITS-1:0] COEF_MED  = 22'd431020;
  localparam logic [COEF_BITS-1:0] COEF_HIGH = 22'd41412;

  typedef struct packed {
    logic                 command;
    logic [ADC_BITS-1:0]  adc_sample;
    logic [TIME_BITS-1:0] now_ms;
  } req_t;

  typedef struct packed {
    logic [LUX_BITS-1:0] average_lux;
    logic                report_cause;
  } rpt_t;

  typedef struct packed {
    logic                 is_status;
    logic [LUX_BITS-1:0]  lux;
    logic [TIME_BITS-1:0] now_ms;
  } q_entry_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIV,
    BK_FIN
  } back_state_t;

  function automatic logic [COEF_BITS-1:0] coef_for(input logic [1:0] gain);
    logic [COEF_BITS-1:0] c;
    case (gain)
      GAIN_LOW:  c = COEF_LOW;
      GAIN_MED:  c = COEF_MED;
      GAIN_HIGH: c = COEF_HIGH;
      default:   c = '0;
    endcase
    return c;
  endfunction

endpackage

// File: rtl/lsba_front.sv
// front end: accepts items, scales samples to lux and pushes queue entries
// depends on lsba_pkg
module lsba_front (
  input  logic                   clk,
  input  logic                   rst,
  input  logic [1:0]             gain_mode,
  input  logic                   req_valid,
  output logic                   req_ready,
  input  lsba_pkg::req_t         req,
  input  logic                   q_full,
  output logic                   q_push,
  output lsba_pkg::q_entry_t     q_din
);

  logic                             stage_valid;
  lsba_pkg::req_t                   stage_req;
  logic [lsba_pkg::PROD_BITS-1:0]   product;

  assign req_ready = !stage_valid || !q_full;
  assign q_push    = stage_valid && !q_full;

  // 10 x 22 bit product stays below 2^32, so the q16.8 value fits 24 bits
  assign product = lsba_pkg::PROD_BITS'(stage_req.adc_sample) *
                   lsba_pkg::PROD_BITS'(lsba_pkg::coef_for(gain_mode));

  always_comb begin
    q_din.is_status = (stage_req.command == lsba_pkg::CMD_STATUS);
    q_din.lux       = product[lsba_pkg::FRAC_SHIFT +: lsba_pkg::LUX_BITS];
    q_din.now_ms    = stage_req.now_ms;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else begin
      stage_valid <= (req_valid && req_ready) || (stage_valid && !q_push);
    end
    if (req_valid && req_ready) begin
      stage_req <= req;
    end
  end

endmodule

// File: rtl/lsba_queue.sv
// short queue of classified items between front and back end
// depends on lsba_pkg
module lsba_queue #(
  parameter int DEPTH = 2
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  lsba_pkg::q_entry_t din,
  output logic               full,
  input  logic               pop,
  output lsba_pkg::q_entry_t dout,
  output logic               empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  lsba_pkg::q_entry_t entries [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   fill;

  assign full  = (fill == CNT_W'(DEPTH));
  assign empty = (fill == '0);
  assign dout  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
    if (push) begin
      entries[wr_ptr] <= din;
    end
  end

endmodule

// File: rtl/lsba_back.sv
// back end: block sum, bit-serial block division and report decision
// depends on lsba_pkg and light_sensor_block_averager_macros.svh
`include "light_sensor_block_averager_macros.svh"

module lsba_back #(
  parameter int COUNT_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic [COUNT_BITS-1:0]           sample_count,
  input  logic [lsba_pkg::TIME_BITS-1:0]  report_interval_ms,
  input  logic                            q_empty,
  input  lsba_pkg::q_entry_t              q_dout,
  output logic                            q_pop,
  output logic                            rpt_valid,
  input  logic                            rpt_ready,
  output lsba_pkg::rpt_t                  rpt
);

  localparam int SB = lsba_pkg::SUM_BITS;
  localparam int LB = lsba_pkg::LUX_BITS;
  localparam int TB = lsba_pkg::TIME_BITS;
  localparam int DW = lsba_pkg::DIV_CNT_W;

  lsba_pkg::back_state_t state, state_next;

  logic [SB-1:0]         lux_sum, lux_sum_next;
  logic [COUNT_BITS-1:0] samples_taken, samples_taken_next;
  logic [LB-1:0]         held_average, held_average_next;
  logic [TB-1:0]         last_report_ms, last_report_ms_next;
  logic [SB-1:0]         div_num, div_num_next;
  logic [COUNT_BITS-1:0] div_rem, div_rem_next;
  logic [DW-1:0]         div_cnt, div_cnt_next;
  logic [TB-1:0]         pend_now, pend_now_next;
  logic                  rpt_valid_next;
  lsba_pkg::rpt_t        rpt_next;

  logic [SB:0]           sum_add;
  logic [SB-1:0]         sum_sat;
  logic [COUNT_BITS-1:0] taken_inc;
  logic                  closes;
  logic [COUNT_BITS:0]   rem_shift;
  logic [COUNT_BITS:0]   rem_sub;
  logic                  rem_ge;
  logic [LB-1:0]         quot_sat;
  logic [TB-1:0]         deadline;
  logic [TB-1:0]         now_sel;
  logic [LB-1:0]         held_sel;
  logic                  due;
  logic                  out_free;
  logic                  load;
  logic                  load_cause;

  assign sum_add   = {1'b0, lux_sum} + (SB + 1)'(q_dout.lux);
  assign sum_sat   = sum_add[SB] ? '1 : sum_add[SB-1:0];
  assign taken_inc = samples_taken + 1'b1;
  assign closes    = (taken_inc >= sample_count);

  assign rem_shift = {div_rem, div_num[SB-1]};
  assign rem_ge    = (rem_shift >= {1'b0, sample_count});
  assign rem_sub   = rem_shift - {1'b0, sample_count};
  assign quot_sat  = (|div_num[SB-1:LB]) ? '1 : div_num[LB-1:0];

  assign deadline  = last_report_ms + report_interval_ms;
  assign now_sel   = (state == lsba_pkg::BK_FIN) ? pend_now : q_dout.now_ms;
  assign held_sel  = (state == lsba_pkg::BK_FIN) ? quot_sat : held_average;
  assign due       = (now_sel > deadline);
  assign out_free  = !rpt_valid || rpt_ready;

  always_comb begin
    state_next          = state;
    lux_sum_next        = lux_sum;
    samples_taken_next  = samples_taken;
    held_average_next   = held_average;
    last_report_ms_next = last_report_ms;
    div_num_next        = div_num;
    div_rem_next        = div_rem;
    div_cnt_next        = div_cnt;
    pend_now_next       = pend_now;
    q_pop               = 1'b0;
    load                = 1'b0;
    load_cause          = lsba_pkg::CAUSE_PERIODIC;
    case (state)
      lsba_pkg::BK_IDLE: begin
        if (!q_empty && out_free) begin
          q_pop = 1'b1;
          if (q_dout.is_status) begin
            load       = 1'b1;
            load_cause = lsba_pkg::CAUSE_STATUS;
          end else if (closes) begin
            lux_sum_next       = '0;
            samples_taken_next = '0;
            div_num_next       = sum_sat;
            div_rem_next       = '0;
            div_cnt_next       = DW'(SB);
            pend_now_next      = q_dout.now_ms;
            state_next         = lsba_pkg::BK_DIV;
          end else begin
            lux_sum_next       = sum_sat;
            samples_taken_next = taken_inc;
            if (due) begin
              load                = 1'b1;
              last_report_ms_next = q_dout.now_ms;
            end
          end
        end
      end
      lsba_pkg::BK_DIV: begin
        // restoring division, one quotient bit a cycle
        div_num_next = {div_num[SB-2:0], rem_ge};
        div_rem_next = rem_ge ? rem_sub[COUNT_BITS-1:0] : rem_shift[COUNT_BITS-1:0];
        div_cnt_next = div_cnt - 1'b1;
        if (div_cnt == DW'(1)) begin
          state_next = lsba_pkg::BK_FIN;
        end
      end
      lsba_pkg::BK_FIN: begin
        held_average_next = quot_sat;
        if (due) begin
          load                = 1'b1;
          last_report_ms_next = pend_now;
        end
        state_next = lsba_pkg::BK_IDLE;
      end
      default: begin
        state_next = lsba_pkg::BK_IDLE;
      end
    endcase
    rpt_valid_next = (rpt_valid && !rpt_ready) || load;
    rpt_next       = rpt;
    if (load) begin
      rpt_next.average_lux  = held_sel;
      rpt_next.report_cause = load_cause;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= lsba_pkg::BK_IDLE;
      lux_sum        <= '0;
      samples_taken  <= '0;
      held_average   <= '0;
      last_report_ms <= '0;
      rpt_valid      <= 1'b0;
    end else begin
      state          <= state_next;
      lux_sum        <= lux_sum_next;
      samples_taken  <= samples_taken_next;
      held_average   <= held_average_next;
      last_report_ms <= last_report_ms_next;
      rpt_valid      <= rpt_valid_next;
    end
    div_num  <= div_num_next;
    div_rem  <= div_rem_next;
    div_cnt  <= div_cnt_next;
    pend_now <= pend_now_next;
    rpt      <= rpt_next;
  end

  `LSBA_ASSERT_NEXT(a_block_clears, clk, rst, state == lsba_pkg::BK_IDLE && state_next == lsba_pkg::BK_DIV, lux_sum == '0 && samples_taken == '0)
  `LSBA_ASSERT_IMPLY(a_div_count_live, clk, rst, state == lsba_pkg::BK_DIV, div_cnt != '0)
  `LSBA_ASSERT_NEXT(a_fin_returns, clk, rst, state == lsba_pkg::BK_FIN, state == lsba_pkg::BK_IDLE)
  `LSBA_ASSERT_IMPLY(a_pop_when_idle, clk, rst, q_pop, state == lsba_pkg::BK_IDLE && !q_empty && out_free)

endmodule

// File: rtl/light_sensor_block_averager.sv
// Light sensor block averager.
// Request channel (req_valid/req_ready/req) carries an adc sample with its
// millisecond time stamp, or a status request. Report channel
// (rpt_valid/rpt_ready/rpt) carries the held block average in q16.8 lux and
// whether it answers a status request or is a periodic report.
// A sample that does not close a block passes the front register and the
// queue, and its report, if any, is registered by the back end; the sample
// that closes a block runs a bit-serial division by sample_count and
// reports, if due, from the finishing state. The back end takes one queued
// item a cycle while the report output is free, except during division and finish.
// A two-entry queue and the front register keep the request side accepting
// while a report waits for the receiver; once they fill, req_ready drops.
// Reset clears the block sum, the sample count, the held average and the
// last report time and loads gain 1, count 1 and a 1000 ms interval.
// Configuration (cfg_wr_en/cfg_index/cfg_data) must be written while idle only; the block does not enforce it.
// depends on lsba_pkg, lsba_front, lsba_queue and lsba_back
module light_sensor_block_averager #(
  parameter int COUNT_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_wr_en,
  input  logic [lsba_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [lsba_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  input  logic                                req_valid,
  output logic                                req_ready,
  input  lsba_pkg::req_t                      req,
  output logic                                rpt_valid,
  input  logic                                rpt_ready,
  output lsba_pkg::rpt_t                      rpt
);

  logic [1:0]                       gain_mode;
  logic [COUNT_BITS-1:0]            sample_count;
  logic [lsba_pkg::TIME_BITS-1:0]   report_interval_ms;
  logic [COUNT_BITS-1:0]            count_wr;

  logic                             q_push;
  logic                             q_pop;
  logic                             q_full;
  logic                             q_empty;
  lsba_pkg::q_entry_t               q_din;
  lsba_pkg::q_entry_t               q_dout;

  assign count_wr = COUNT_BITS'(cfg_data[15:0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      gain_mode          <= lsba_pkg::GAIN_LOW;
      sample_count       <= COUNT_BITS'(1);
      report_interval_ms <= lsba_pkg::INTERVAL_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        lsba_pkg::CFG_GAIN_MODE: begin
          gain_mode <= cfg_data[1:0];
        end
        lsba_pkg::CFG_SAMPLE_COUNT: begin
          sample_count <= (count_wr == '0) ? COUNT_BITS'(1) : count_wr;
        end
        lsba_pkg::CFG_REPORT_INTERVAL: begin
          report_interval_ms <= cfg_data[lsba_pkg::TIME_BITS-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  lsba_front u_front (
    .clk       (clk),
    .rst       (rst),
    .gain_mode (gain_mode),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_din     (q_din)
  );

  lsba_queue #(
    .DEPTH (2)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .din   (q_din),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (q_dout),
    .empty (q_empty)
  );

  lsba_back #(
    .COUNT_BITS (COUNT_BITS)
  ) u_back (
    .clk                (clk),
    .rst                (rst),
    .sample_count       (sample_count),
    .report_interval_ms (report_interval_ms),
    .q_empty            (q_empty),
    .q_dout             (q_dout),
    .q_pop              (q_pop),
    .rpt_valid          (rpt_valid),
    .rpt_ready          (rpt_ready),
    .rpt                (rpt)
  );

endmodule
